/* hdl/tasc_pkg.sv */
// tasc_pkg: word types, phase codes and control byte constants for the
// touch ADC scan sequencer. No dependencies.
package tasc_pkg;

    typedef struct packed {
        logic [1:0] op;
        logic       pen_down;
        logic [7:0] rx_byte;
    } tasc_in_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        chip_select_active;
        logic        done_res;
        logic [15:0] x_position;
        logic [15:0] y_position;
    } tasc_out_t;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_RX     = 2'd1;
    localparam logic [1:0] OP_PWDN   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [0:0] REG_REF_MODE    = 1'd0;
    localparam logic [0:0] REG_MAX_SAMPLES = 1'd1;

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_CTRL_X   = 4'd1;
    localparam logic [3:0] PH_HI_X     = 4'd2;
    localparam logic [3:0] PH_LO_X     = 4'd3;
    localparam logic [3:0] PH_HI_Y     = 4'd4;
    localparam logic [3:0] PH_LO_Y     = 4'd5;
    localparam logic [3:0] PH_DFR_ZERO = 4'd6;
    localparam logic [3:0] PH_PD_CTRL  = 4'd7;
    localparam logic [3:0] PH_FLUSH_A  = 4'd8;
    localparam logic [3:0] PH_FLUSH_B  = 4'd9;

    localparam logic [3:0]  CTRL_X_HI  = 4'b1001;
    localparam logic [3:0]  CTRL_Y_HI  = 4'b1101;
    localparam logic [3:0]  LO_DIFF    = 4'b0011;
    localparam logic [3:0]  LO_SINGLE  = 4'b0100;
    localparam logic [7:0]  CTRL_PWDN  = {CTRL_Y_HI, LO_SINGLE};
    localparam logic [15:0] NO_TOUCH   = 16'hffff;

endpackage

/* hdl/touch_adc_scan_sequencer.sv */
// touch_adc_scan_sequencer: byte-level SPI scan sequencer for a resistive
// touch ADC, one result word per input word. Depends on tasc_pkg.
//
//  channel   direction  handshake           payload
//  s_        in         s_valid/s_ready     tasc_in_t   (op, pen_down, rx_byte)
//  m_        out        m_valid/m_ready     tasc_out_t  (tx, cs, done, x, y)
//  cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word per cycle while s_ready is high: the phase logic runs in the accepting
// cycle and the result lands in the output register, shown on m_ next cycle.
// s_ready is high while the output register is empty or being emptied.
// Synchronous active-low reset; cfg_ready is always high.
module touch_adc_scan_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tasc_pkg::tasc_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tasc_pkg::tasc_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import tasc_pkg::*;

    logic        ref_mode_reg;
    logic [7:0]  max_samples_reg;
    logic [3:0]  phase_reg,     phase_next;
    logic [7:0]  count_reg,     count_next;
    logic [11:0] prev_reg,      prev_next;
    logic        prev_ok_reg,   prev_ok_next;
    logic [7:0]  high_reg,      high_next;
    logic [11:0] x_reg,         x_next;
    logic [11:0] y_reg,         y_next;
    logic        single_reg,    single_next;
    logic        out_valid_reg;
    tasc_out_t   out_reg,       out_next;

    logic        accept;
    logic [11:0] sample;
    logic [8:0]  cnt_inc;
    logic [8:0]  limit;
    logic        settled;
    logic [3:0]  nibble;

    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    assign nibble  = single_reg ? LO_SINGLE : LO_DIFF;
    assign sample  = {high_reg, s_data.rx_byte[7:4]};
    assign cnt_inc = {1'b0, count_reg} + 9'd1;
    assign limit   = (max_samples_reg == 8'd0) ? 9'd1 : {1'b0, max_samples_reg};
    assign settled = (prev_ok_reg && prev_reg == sample) || (cnt_inc >= limit);

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        prev_next    = prev_reg;
        prev_ok_next = prev_ok_reg;
        high_next    = high_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        single_next  = single_reg;
        out_next     = '0;

        if (s_data.op != OP_RX) begin
            if (phase_reg != PH_IDLE || s_data.op == OP_UNUSED) begin
                out_next.chip_select_active = (phase_reg != PH_IDLE);
            end else if (s_data.op == OP_PWDN) begin
                phase_next                  = PH_PD_CTRL;
                out_next.tx_byte            = CTRL_PWDN;
                out_next.tx_valid           = 1'b1;
                out_next.chip_select_active = 1'b1;
            end else if (!s_data.pen_down) begin
                out_next.done_res   = 1'b1;
                out_next.x_position = NO_TOUCH;
                out_next.y_position = NO_TOUCH;
            end else begin
                single_next                 = ref_mode_reg;
                count_next                  = '0;
                prev_ok_next                = 1'b0;
                phase_next                  = PH_CTRL_X;
                out_next.tx_byte            = {CTRL_X_HI, ref_mode_reg ? LO_SINGLE : LO_DIFF};
                out_next.tx_valid           = 1'b1;
                out_next.chip_select_active = 1'b1;
            end
        end else begin
            out_next.tx_valid           = 1'b1;
            out_next.chip_select_active = 1'b1;
            case (phase_reg)
                PH_CTRL_X: begin
                    phase_next = PH_HI_X;
                end
                PH_HI_X: begin
                    high_next        = s_data.rx_byte;
                    phase_next       = PH_LO_X;
                    out_next.tx_byte = {CTRL_X_HI, nibble};
                end
                PH_HI_Y: begin
                    high_next        = s_data.rx_byte;
                    phase_next       = PH_LO_Y;
                    out_next.tx_byte = {CTRL_Y_HI, nibble};
                end
                PH_LO_X, PH_LO_Y: begin
                    prev_next    = sample;
                    prev_ok_next = 1'b1;
                    count_next   = cnt_inc[7:0];
                    if (!settled) begin
                        phase_next = phase_reg - 4'd1;
                    end else if (phase_reg == PH_LO_X) begin
                        x_next       = sample;
                        count_next   = '0;
                        prev_ok_next = 1'b0;
                        phase_next   = PH_HI_Y;
                    end else begin
                        y_next     = sample;
                        phase_next = single_reg ? PH_FLUSH_A : PH_DFR_ZERO;
                    end
                end
                PH_DFR_ZERO: begin
                    phase_next       = PH_PD_CTRL;
                    out_next.tx_byte = CTRL_PWDN;
                end
                PH_PD_CTRL: begin
                    phase_next = PH_FLUSH_A;
                end
                PH_FLUSH_A: begin
                    phase_next = PH_FLUSH_B;
                end
                PH_FLUSH_B: begin
                    phase_next                  = PH_IDLE;
                    out_next.tx_valid           = 1'b0;
                    out_next.chip_select_active = 1'b0;
                    out_next.done_res           = 1'b1;
                    out_next.x_position         = {4'd0, x_reg};
                    out_next.y_position         = {4'd0, y_reg};
                    x_next                      = '0;
                    y_next                      = '0;
                end
                default: begin
                    phase_next                  = PH_IDLE;
                    out_next.tx_valid           = 1'b0;
                    out_next.chip_select_active = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_mode_reg    <= 1'b0;
            max_samples_reg <= 8'd4;
            phase_reg       <= PH_IDLE;
            count_reg       <= '0;
            prev_reg        <= '0;
            prev_ok_reg     <= 1'b0;
            high_reg        <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            single_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_REF_MODE:    ref_mode_reg    <= cfg_data[0];
                    REG_MAX_SAMPLES: max_samples_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (accept) begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                prev_reg    <= prev_next;
                prev_ok_reg <= prev_ok_next;
                high_reg    <= high_next;
                x_reg       <= x_next;
                y_reg       <= y_next;
                single_reg  <= single_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

endmodule

/* tb/touch_adc_scan_sequencer_chk.sv */
`timescale 1ns / 100ps
// Scoreboard for the touch ADC scan sequencer: watches the s_, m_ and cfg_
// channels, predicts each result word and compares it. Depends on tasc_pkg.
module touch_adc_scan_sequencer_chk (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  tasc_pkg::tasc_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  tasc_pkg::tasc_out_t m_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output int                  errors,
    output int                  pending,
    output int                  checked,
    output int                  seq_ended
);
    import tasc_pkg::*;

    logic        single_ended = 1'b0;
    logic [7:0]  sample_limit = 8'd4;

    logic [3:0]  phase_q   = PH_IDLE;
    logic [7:0]  samples_q = '0;
    logic [15:0] last_smp  = NO_TOUCH;
    logic [7:0]  msb_byte  = '0;
    logic [15:0] x_hold    = '0;
    logic [15:0] y_hold    = '0;
    logic [3:0]  ctrl_lo   = LO_DIFF;

    tasc_out_t   result_q[$];
    tasc_out_t   want;
    int          fails    = 0;
    int          n_chk    = 0;
    int          n_done   = 0;

    function automatic tasc_out_t scan_step(input tasc_in_t w);
        tasc_out_t   r;
        logic [15:0] smp;
        logic [15:0] lim;
        logic [15:0] cnt;
        logic        settled;
        r = '0;
        if (w.op != OP_RX) begin
            if (phase_q != PH_IDLE) begin
                r.chip_select_active = 1'b1;
            end else begin
                case (w.op)
                    OP_PWDN: begin
                        phase_q              = PH_PD_CTRL;
                        r.tx_byte            = CTRL_PWDN;
                        r.tx_valid           = 1'b1;
                        r.chip_select_active = 1'b1;
                    end
                    OP_START: begin
                        if (!w.pen_down) begin
                            r.done_res   = 1'b1;
                            r.x_position = NO_TOUCH;
                            r.y_position = NO_TOUCH;
                        end else begin
                            ctrl_lo              = single_ended ? LO_SINGLE : LO_DIFF;
                            samples_q            = '0;
                            last_smp             = NO_TOUCH;
                            phase_q              = PH_CTRL_X;
                            r.tx_byte            = {CTRL_X_HI, ctrl_lo};
                            r.tx_valid           = 1'b1;
                            r.chip_select_active = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            return r;
        end
        r.tx_valid           = 1'b1;
        r.chip_select_active = 1'b1;
        case (phase_q)
            PH_CTRL_X: phase_q = PH_HI_X;
            PH_HI_X, PH_HI_Y: begin
                msb_byte  = w.rx_byte;
                phase_q   = phase_q + 4'd1;
                r.tx_byte = {(phase_q == PH_LO_X) ? CTRL_X_HI : CTRL_Y_HI, ctrl_lo};
            end
            PH_LO_X, PH_LO_Y: begin
                smp       = {4'h0, msb_byte, w.rx_byte[7:4]};
                lim       = (sample_limit == 8'd0) ? 16'd1 : {8'd0, sample_limit};
                cnt       = {8'd0, samples_q} + 16'd1;
                settled   = (last_smp == smp) || (cnt >= lim);
                last_smp  = smp;
                samples_q = cnt[7:0];
                if (!settled) begin
                    phase_q = phase_q - 4'd1;
                end else if (phase_q == PH_LO_X) begin
                    x_hold    = smp;
                    samples_q = '0;
                    last_smp  = NO_TOUCH;
                    phase_q   = PH_HI_Y;
                end else begin
                    y_hold  = smp;
                    phase_q = (ctrl_lo == LO_DIFF) ? PH_DFR_ZERO : PH_FLUSH_A;
                end
            end
            PH_DFR_ZERO: begin
                phase_q   = PH_PD_CTRL;
                r.tx_byte = CTRL_PWDN;
            end
            PH_PD_CTRL: phase_q = PH_FLUSH_A;
            PH_FLUSH_A: phase_q = PH_FLUSH_B;
            PH_FLUSH_B: begin
                phase_q              = PH_IDLE;
                r.tx_valid           = 1'b0;
                r.chip_select_active = 1'b0;
                r.done_res           = 1'b1;
                r.x_position         = x_hold;
                r.y_position         = y_hold;
                x_hold               = '0;
                y_hold               = '0;
            end
            default: begin
                // received byte while idle
                phase_q = PH_IDLE;
                r       = '0;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            single_ended = 1'b0;
            sample_limit = 8'd4;
            phase_q      = PH_IDLE;
            samples_q    = '0;
            last_smp     = NO_TOUCH;
            msb_byte     = '0;
            x_hold       = '0;
            y_hold       = '0;
            ctrl_lo      = LO_DIFF;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    check_field("tx_byte", 16'(want.tx_byte), 16'(m_data.tx_byte));
                    check_field("tx_valid", 16'(want.tx_valid), 16'(m_data.tx_valid));
                    check_field("chip_select_active", 16'(want.chip_select_active),
                                16'(m_data.chip_select_active));
                    check_field("done_res", 16'(want.done_res), 16'(m_data.done_res));
                    check_field("x_position", want.x_position, m_data.x_position);
                    check_field("y_position", want.y_position, m_data.y_position);
                    n_chk++;
                    if (want.done_res) n_done++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_REF_MODE:    single_ended = cfg_data[0];
                    REG_MAX_SAMPLES: sample_limit = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) result_q.push_back(scan_step(s_data));
        end
        errors    <= fails;
        pending   <= result_q.size();
        checked   <= n_chk;
        seq_ended <= n_done;
    end

endmodule

/* tb/touch_adc_scan_sequencer_tb.sv */
`timescale 1ns / 100ps
// Top of the touch ADC scan sequencer testbench: clock, reset, stimulus and
// verdict. Depends on tasc_pkg, the block and touch_adc_scan_sequencer_chk.
module touch_adc_scan_sequencer_tb;
    import tasc_pkg::*;

    localparam int         HOLD_LEN  = 300;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    tasc_in_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    tasc_out_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_index = REG_REF_MODE;
    logic [7:0] cfg_data  = '0;

    int errors, pending, checked, seq_ended;

    int tx_idle_pct = 12;
    int rx_idle_pct = 70;
    int hold_asks   = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int words_sent  = 0;
    int reg_writes  = 0;

    logic       cur_mode  = 1'b0;
    logic [7:0] cur_limit = 8'd4;

    always #6 aclk = ~aclk;

    touch_adc_scan_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    touch_adc_scan_sequencer_chk u_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .seq_ended (seq_ended)
    );

    // result side: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            m_ready   <= 1'b0;
            hold_seen <= hold_asks;
            hold_left <= HOLD_LEN;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic tasc_in_t mk_word(input logic [1:0] op, input logic pen,
                                         input logic [7:0] rx);
        tasc_in_t w;
        w.op       = op;
        w.pen_down = pen;
        w.rx_byte  = rx;
        return w;
    endfunction

    task automatic send_word(input tasc_in_t w);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_word(mk_word(OP_RX, 1'($urandom_range(1)), b));
    endtask

    task automatic settle_out();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
        settle_out();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == REG_REF_MODE) cur_mode = val[0];
        else cur_limit = val;
    endtask

    // one axis: either runs to the sample limit or settles on a repeat
    task automatic send_axis();
        int          eff;
        int          n;
        logic        by_limit;
        logic [11:0] smp;
        logic [11:0] prev;
        eff      = (cur_limit == 8'd0) ? 1 : int'(cur_limit);
        by_limit = (eff == 1) || ((eff <= 8) && ($urandom_range(2) == 0));
        n        = by_limit ? eff : $urandom_range(2, (eff < 6) ? eff : 6);
        prev     = '0;
        for (int i = 1; i <= n; i++) begin
            if (!by_limit && i == n) begin
                smp = prev;
            end else begin
                smp = 12'($urandom_range(4095));
                if (i > 1 && smp == prev) smp = ~smp;
            end
            send_rx(smp[11:4]);
            send_rx({smp[3:0], 4'($urandom_range(15))});
            prev = smp;
        end
    endtask

    task automatic full_scan();
        send_word(mk_word(OP_START, 1'b1, 8'($urandom_range(255))));
        send_rx(8'($urandom_range(255)));
        send_axis();
        send_axis();
        repeat (cur_mode ? 2 : 4) send_rx(8'($urandom_range(255)));
    endtask

    task automatic power_down();
        send_word(mk_word(OP_PWDN, 1'($urandom_range(1)), 8'($urandom_range(255))));
        repeat (3) send_rx(8'($urandom_range(255)));
    endtask

    // random words and cut-short scans, then enough bytes to reach idle again
    task automatic noise_burst();
        int eff;
        eff = (cur_limit == 8'd0) ? 1 : int'(cur_limit);
        if ($urandom_range(1)) begin
            send_word(mk_word(OP_START, 1'b1, 8'($urandom_range(255))));
            repeat ($urandom_range(0, 6)) send_rx(8'($urandom_range(255)));
        end
        repeat ($urandom_range(3, 10))
            send_word(mk_word(2'($urandom_range(3)), 1'($urandom_range(1)),
                              8'($urandom_range(255))));
        repeat (4 * eff + 6) send_rx(8'($urandom_range(255)));
    endtask

    task automatic mixed_traffic(input int budget);
        int start_cnt;
        int pick;
        start_cnt = words_sent;
        while (words_sent - start_cnt < budget) begin
            pick = $urandom_range(99);
            if (pick < 70) full_scan();
            else if (pick < 78)
                send_word(mk_word(OP_START, 1'b0, 8'($urandom_range(255))));
            else if (pick < 88) power_down();
            else if (cur_limit <= 8'd8) noise_burst();
            else full_scan();
        end
    endtask

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic       modes [8];
        logic [7:0] limits[8];
        modes  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        limits = '{8'd0, 8'd1, 8'($urandom_range(2, 8)), 8'd255, 8'd3,
                   8'($urandom_range(2, 8)), 8'd2, 8'($urandom_range(255))};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: pen up, stray words, power-down, a settled diff scan
        send_word(mk_word(OP_START, 1'b0, 8'h00));
        send_word(mk_word(OP_RX, 1'b1, 8'hff));
        send_word(mk_word(OP_UNUSED, 1'b1, 8'hff));
        send_word(mk_word(OP_PWDN, 1'b0, 8'h00));
        send_word(mk_word(OP_START, 1'b1, 8'h00));
        send_rx(8'hff);
        send_rx(8'h00);
        send_rx(8'h5a);
        send_word(mk_word(OP_START, 1'b1, 8'hff));
        send_rx(8'h00);
        send_rx(8'hff);
        send_rx(8'hf0);
        send_rx(8'hff);
        send_rx(8'hff);
        send_rx(8'h00);
        send_rx(8'h00);
        send_rx(8'h00);
        send_rx(8'h0f);
        repeat (4) send_rx(8'ha5);

        for (int k = 0; k < 8; k++) begin
            if (k < 3) begin
                tx_idle_pct = 12;
                rx_idle_pct = 70;
            end else if (k < 6) begin
                tx_idle_pct = 70;
                rx_idle_pct = 12;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_reg(REG_REF_MODE, {7'($urandom_range(127)), modes[k]});
            write_reg(REG_MAX_SAMPLES, limits[k]);
            if (k == 0 || k == 6) hold_asks++;
            mixed_traffic(185);
        end

        settle_out();
        repeat (10) @(posedge aclk);
        $display("Covered %0d input words and %0d checked result words, %0d sequences ended.",
                 words_sent, checked, seq_ended);
        $display("Made %0d register writes over both reference modes and limits 0 to 255.",
                 reg_writes);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/tasc_pkg.sv
hdl/touch_adc_scan_sequencer.sv
tb/touch_adc_scan_sequencer_chk.sv
tb/touch_adc_scan_sequencer_tb.sv
